### hw/rtl/lskv_pkg.sv
// Shared types and codes for the linear-search key-value table.
package lskv_pkg;

    localparam int FIELD_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        func_t func;
        logic  hit;
        logic  scan_end;
        logic  cmp_pending;
    } dp_status_t;

endpackage

### hw/rtl/lskv_ctrl.sv
// Controller state machine for the key-value table: sequences load, scan and commit.
module lskv_ctrl
    import lskv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;
    logic   scan_done;

    // The scan is over on a hit, or once every held slot has been read and compared.
    assign scan_done = sts.hit || (sts.scan_end && !sts.cmp_pending);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.func == FUNC_PUT || sts.func == FUNC_LOOKUP)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DECODE:
            begin
                cmd.commit = !(sts.func == FUNC_PUT || sts.func == FUNC_LOOKUP);
            end
            ST_SCAN:
            begin
                cmd.commit = scan_done;
                cmd.step   = !sts.hit && !sts.scan_end;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### hw/rtl/lskv_datapath.sv
// Datapath of the key-value table: key and value memories, scan pointer, count and result.
module lskv_datapath
    import lskv_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          sts,
    input  logic [FUNC_W-1:0]   func,
    input  logic [FIELD_W-1:0]  lookup_key,
    input  logic [FIELD_W-1:0]  entry_value,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic                found,
    output logic [FIELD_W-1:0]  read_value,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int KW   = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int VW   = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CXW  = (CW > COUNT_W) ? CW : COUNT_W;

    logic [KW-1:0] key_mem [CAPACITY];
    logic [VW-1:0] val_mem [CAPACITY];

    func_t         func_reg;
    logic [KW-1:0] key_reg;
    logic [VW-1:0] value_reg;
    logic [CW-1:0] scan_idx_reg;
    logic          cmp_pending_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic [KW-1:0] key_rd_reg;
    logic [VW-1:0] val_rd_reg;
    logic [CW-1:0] fill_count_reg;
    logic [CW-1:0] fill_count_next;

    logic                done_reg;
    status_t             status_reg;
    status_t             status_next;
    logic                found_reg;
    logic                found_next;
    logic [FIELD_W-1:0]  read_value_reg;
    logic [FIELD_W-1:0]  read_value_next;
    logic [COUNT_W-1:0]  entry_count_reg;
    logic [CXW-1:0]      count_ext;

    logic          hit;
    logic          room;
    logic          key_we;
    logic          val_we;
    logic [AW-1:0] wr_addr;

    assign hit  = cmp_pending_reg && (key_rd_reg == key_reg);
    assign room = fill_count_reg < CW'(CAPACITY);

    assign sts.func        = func_reg;
    assign sts.hit         = hit;
    assign sts.scan_end    = scan_idx_reg >= fill_count_reg;
    assign sts.cmp_pending = cmp_pending_reg;

    // Outcome of the operation and the memory update it implies.
    always_comb
    begin
        status_next     = STATUS_OK;
        found_next      = 1'b0;
        read_value_next = '0;
        fill_count_next = fill_count_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        wr_addr         = fill_count_reg[AW-1:0];
        unique case (func_reg)
            FUNC_PUT:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    val_we     = cmd.commit;
                    wr_addr    = cmp_idx_reg;
                end
                else if (room)
                begin
                    key_we          = cmd.commit;
                    val_we          = cmd.commit;
                    fill_count_next = fill_count_reg + 1'b1;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            FUNC_LOOKUP:
            begin
                if (hit)
                begin
                    found_next      = 1'b1;
                    read_value_next = FIELD_W'(val_rd_reg);
                end
                else
                begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            FUNC_CLEAR:
            begin
                fill_count_next = '0;
            end
            FUNC_NOP:
            begin
                fill_count_next = fill_count_reg;
            end
            default:
            begin
                fill_count_next = fill_count_reg;
            end
        endcase
    end

    assign count_ext = CXW'(fill_count_next);

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (val_we)
        begin
            val_mem[wr_addr] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            key_rd_reg <= key_mem[scan_idx_reg[AW-1:0]];
            val_rd_reg <= val_mem[scan_idx_reg[AW-1:0]];
        end
    end

    // Operation operands and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func_t'(func);
            key_reg   <= lookup_key[KW-1:0];
            value_reg <= entry_value[VW-1:0];
        end
        if (cmd.step)
        begin
            cmp_idx_reg <= scan_idx_reg[AW-1:0];
        end
        if (cmd.commit)
        begin
            status_reg      <= status_next;
            found_reg       <= found_next;
            read_value_reg  <= read_value_next;
            entry_count_reg <= count_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg    <= '0;
            cmp_pending_reg <= 1'b0;
            fill_count_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
            if (cmd.load)
            begin
                scan_idx_reg    <= '0;
                cmp_pending_reg <= 1'b0;
            end
            else
            begin
                cmp_pending_reg <= cmd.step;
                if (cmd.step)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            if (cmd.commit)
            begin
                fill_count_reg <= fill_count_next;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign entry_count = entry_count_reg;

endmodule

### hw/rtl/linear_search_key_value_table_top.sv
// Top level of the linear-search key-value table.
//
// The block holds up to CAPACITY key-value pairs. An operation is handed over
// as a transfer at a rising edge where start is high and busy is low; func
// selects put, lookup, clear or no operation, with lookup_key and entry_value.
// Each operation gives exactly one result: done is high for one cycle while
// status, found, read_value and entry_count carry it. The receiver cannot
// hold a result off, so the result registers simply hold until the next one.
//
// Timing: a put or lookup scans the held pairs one per cycle through the key
// memory's registered read port, stopping at the first hit or after the last
// held pair; a search of an empty table reads no slot. Clear and no operation
// end straight from the decode state, with no scan. The result is shown in the
// first cycle with busy low, in which a new operation may already be taken.
// Reset empties the table at once by zeroing the fill count; the memories are
// not swept, as slots past the count are never read.
module linear_search_key_value_table_top
    import lskv_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [FIELD_W-1:0]  lookup_key,
    input  logic [FIELD_W-1:0]  entry_value,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic                found,
    output logic [FIELD_W-1:0]  read_value,
    output logic [COUNT_W-1:0]  entry_count
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // The controller sequences from the datapath's status; all data storage and result decisions sit in the datapath.
    lskv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    lskv_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .lookup_key  (lookup_key),
        .entry_value (entry_value),
        .done        (done),
        .status      (status),
        .found       (found),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

endmodule

### hw/rtl/lskv_checker.sv
// Port-level checker for the key-value table, bound to the top level.
module lskv_checker
    import lskv_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic                found,
    input logic [FIELD_W-1:0]  read_value
);

    // A found key always reports success.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == STATUS_OK))
        else $error("found set with a failing status");

    // A failed operation never carries a value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (read_value == '0 && !found))
        else $error("failed operation carries data");

    // An accepted operation keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after transfer");

    // A result follows the end of an operation, never during one.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of an operation");

endmodule

bind linear_search_key_value_table_top lskv_checker u_lskv_checker (.*);
